[rtl/utc_pkg.sv]
// Shared types and constants for the Unicode transcoder.
// Used by the front decoder, the queue, the back encoder and the top level.
`timescale 1ns / 1ps

package utc_pkg;

   // Encoding form codes for the source and target registers. Code three acts as UTF-32.
   localparam logic [1:0] FMT_UTF8  = 2'd0;
   localparam logic [1:0] FMT_UTF16 = 2'd1;
   localparam logic [1:0] FMT_UTF32 = 2'd2;

   // Configuration register indexes.
   localparam int          CSR_INDEX_WIDTH   = 2;
   localparam logic [1:0]  CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0]  CSR_TARGET_FORMAT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [1:0] SOURCE_FORMAT_RESET = FMT_UTF8;
   localparam logic [1:0] TARGET_FORMAT_RESET = FMT_UTF16;

   // Codepoint constants.
   localparam logic [31:0] REPLACEMENT_CHAR = 32'h0000_FFFD;
   localparam logic [31:0] SUPPLEMENT_BASE  = 32'h0001_0000;
   localparam logic [31:0] LOW_SURR_BASE    = 32'h0000_DC00;
   localparam logic [15:0] HIGH_SURR_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LAST    = 16'hDFFF;
   localparam logic [31:0] MAX_CODEPOINT    = 32'h0010_FFFF;

   // Default depth of the queue between decoder and encoder.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One decoded request as it travels from the front to the back.
   typedef struct packed {
      logic [31:0] codepoint;
      logic        have_cp;
      logic        last;
   } utc_entry_type;

   // Fill status of the queue.
   typedef struct packed {
      logic full;
      logic empty;
   } utc_queue_status_type;

endpackage

[rtl/utc_front.sv]
// Front decoder: accepts source code units and turns them into codepoints.
// Depends on utc_pkg; feeds utc_queue.
`timescale 1ns / 1ps

module utc_front import utc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    source_format,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_code_unit,
   input  logic          req_last_unit,
   input  utc_queue_status_type queue_status,
   output logic          push_valid,
   output utc_entry_type push_data
);

   logic [20:0] partial_value_ff, partial_value_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [9:0]  high_half_ff, high_half_in;
   logic        high_pending_ff, high_pending_in;

   logic        accept;
   logic        have_cp;
   logic [31:0] codepoint;
   logic [7:0]  byte_unit;
   logic [15:0] word_unit;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign byte_unit = req_code_unit[7:0];
   assign word_unit = req_code_unit[15:0];

   // Decode one unit against the state of the selected source form.
   always_comb begin
      partial_value_in = partial_value_ff;
      bytes_left_in    = bytes_left_ff;
      high_half_in     = high_half_ff;
      high_pending_in  = high_pending_ff;
      have_cp          = 1'b0;
      codepoint        = '0;
      case (source_format)
         FMT_UTF8: begin
            if (bytes_left_ff == 2'd0) begin
               if (!byte_unit[7]) begin
                  codepoint = {24'd0, byte_unit};
                  have_cp   = 1'b1;
               end else if (byte_unit[7:5] == 3'b110) begin
                  partial_value_in = {16'd0, byte_unit[4:0]};
                  bytes_left_in    = 2'd1;
               end else if (byte_unit[7:4] == 4'b1110) begin
                  partial_value_in = {17'd0, byte_unit[3:0]};
                  bytes_left_in    = 2'd2;
               end else if (byte_unit[7:3] == 5'b11110) begin
                  partial_value_in = {18'd0, byte_unit[2:0]};
                  bytes_left_in    = 2'd3;
               end else begin
                  codepoint = REPLACEMENT_CHAR;
                  have_cp   = 1'b1;
               end
            end else begin
               partial_value_in = {partial_value_ff[14:0], byte_unit[5:0]};
               bytes_left_in    = bytes_left_ff - 2'd1;
               if (bytes_left_in == 2'd0) begin
                  codepoint = {11'd0, partial_value_in};
                  have_cp   = 1'b1;
               end
            end
            // A truncated final sequence is padded with zero payload bits.
            if (req_last_unit && bytes_left_in != 2'd0) begin
               have_cp = 1'b1;
               case (bytes_left_in)
                  2'd1:    codepoint = {11'd0, partial_value_in[14:0], 6'd0};
                  2'd2:    codepoint = {11'd0, partial_value_in[8:0], 12'd0};
                  default: codepoint = {11'd0, partial_value_in[2:0], 18'd0};
               endcase
            end
         end
         FMT_UTF16: begin
            if (high_pending_ff) begin
               // The partner unit is taken unchecked, with wrapping arithmetic.
               codepoint = SUPPLEMENT_BASE + {12'd0, high_half_ff, 10'd0}
                         + {16'd0, word_unit} - LOW_SURR_BASE;
               high_pending_in = 1'b0;
               have_cp         = 1'b1;
            end else if (word_unit < HIGH_SURR_FIRST || word_unit > LOW_SURR_LAST) begin
               codepoint = {16'd0, word_unit};
               have_cp   = 1'b1;
            end else if (word_unit <= HIGH_SURR_LAST) begin
               high_half_in    = word_unit[9:0];
               high_pending_in = 1'b1;
               if (req_last_unit) begin
                  codepoint = SUPPLEMENT_BASE + {12'd0, word_unit[9:0], 10'd0};
                  have_cp   = 1'b1;
               end
            end else begin
               codepoint = REPLACEMENT_CHAR;
               have_cp   = 1'b1;
            end
         end
         default: begin
            codepoint = req_code_unit;
            have_cp   = 1'b1;
         end
      endcase
      // The end of a string clears every decoder.
      if (req_last_unit) begin
         partial_value_in = '0;
         bytes_left_in    = '0;
         high_half_in     = '0;
         high_pending_in  = 1'b0;
      end
   end

   // Only requests that produce a codepoint or close a string go to the queue.
   assign push_valid          = accept && (have_cp || req_last_unit);
   assign push_data.codepoint = codepoint;
   assign push_data.have_cp   = have_cp;
   assign push_data.last      = req_last_unit;

   // Decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_value_ff <= '0;
         bytes_left_ff    <= '0;
         high_half_ff     <= '0;
         high_pending_ff  <= 1'b0;
      end else if (accept) begin
         partial_value_ff <= partial_value_in;
         bytes_left_ff    <= bytes_left_in;
         high_half_ff     <= high_half_in;
         high_pending_ff  <= high_pending_in;
      end
   end

endmodule

[rtl/utc_queue.sv]
// Short queue of decoded entries between the front decoder and back encoder.
// Depends on utc_pkg for the entry and status types.
`timescale 1ns / 1ps

module utc_queue import utc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  utc_entry_type push_data,
   input  logic          pop,
   output utc_entry_type head_data,
   output utc_queue_status_type status
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   utc_entry_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/utc_back.sv]
// Back encoder: turns queued codepoints into target code units, one per cycle while the response channel takes them.
// Depends on utc_pkg; reads from utc_queue and drives the response channel.
`timescale 1ns / 1ps

module utc_back import utc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    target_format,
   input  utc_entry_type head_data,
   input  utc_queue_status_type queue_status,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_out_unit,
   output logic          rsp_run_last,
   output logic          rsp_terminator
);

   logic [2:0]  unit_idx_ff, unit_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_out_unit_ff, rsp_out_unit_in;
   logic        rsp_run_last_ff, rsp_run_last_in;
   logic        rsp_terminator_ff, rsp_terminator_in;

   logic [31:0] enc_unit [4];
   logic [2:0]  enc_count;
   logic [2:0]  total_count;
   logic [20:0] offset_cp;
   logic [31:0] cp;
   logic        slot_free;
   logic        emit;
   logic        final_unit;

   assign cp        = head_data.codepoint;
   assign offset_cp = cp[20:0] - 21'h01_0000;

   // Encode the head codepoint into up to four target units.
   always_comb begin
      enc_count = 3'd0;
      for (int i = 0; i < 4; i++) begin
         enc_unit[i] = '0;
      end
      case (target_format)
         FMT_UTF8: begin
            if (cp <= 32'h7F) begin
               enc_count   = 3'd1;
               enc_unit[0] = cp;
            end else if (cp <= 32'h7FF) begin
               enc_count   = 3'd2;
               enc_unit[0] = {24'd0, 3'b110, cp[10:6]};
               enc_unit[1] = {24'd0, 2'b10, cp[5:0]};
            end else if (cp <= 32'hFFFF) begin
               enc_count   = 3'd3;
               enc_unit[0] = {24'd0, 4'b1110, cp[15:12]};
               enc_unit[1] = {24'd0, 2'b10, cp[11:6]};
               enc_unit[2] = {24'd0, 2'b10, cp[5:0]};
            end else if (cp <= MAX_CODEPOINT) begin
               enc_count   = 3'd4;
               enc_unit[0] = {24'd0, 5'b11110, cp[20:18]};
               enc_unit[1] = {24'd0, 2'b10, cp[17:12]};
               enc_unit[2] = {24'd0, 2'b10, cp[11:6]};
               enc_unit[3] = {24'd0, 2'b10, cp[5:0]};
            end
         end
         FMT_UTF16: begin
            if (cp <= 32'hFFFF) begin
               enc_count   = 3'd1;
               enc_unit[0] = cp;
            end else if (cp <= MAX_CODEPOINT) begin
               enc_count   = 3'd2;
               enc_unit[0] = {16'd0, 6'b110110, offset_cp[19:10]};
               enc_unit[1] = {16'd0, 6'b110111, offset_cp[9:0]};
            end
         end
         default: begin
            enc_count   = 3'd1;
            enc_unit[0] = cp;
         end
      endcase
      if (!head_data.have_cp) begin
         enc_count = 3'd0;
      end
   end

   // Units for this entry, the terminator included.
   assign total_count = enc_count + {2'd0, head_data.last};
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign emit        = !queue_status.empty && (total_count != 3'd0) && slot_free;
   assign final_unit  = (unit_idx_ff == total_count - 3'd1);

   // An entry that encodes to nothing is dropped without output.
   assign pop = (emit && final_unit)
             || (!queue_status.empty && (total_count == 3'd0));

   // Output register and unit index.
   always_comb begin
      unit_idx_in       = unit_idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_out_unit_in   = rsp_out_unit_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_terminator_in = rsp_terminator_ff;
      if (emit) begin
         rsp_valid_in      = 1'b1;
         rsp_run_last_in   = final_unit;
         rsp_terminator_in = head_data.last && (unit_idx_ff == enc_count);
         rsp_out_unit_in   = (unit_idx_ff < enc_count) ? enc_unit[unit_idx_ff[1:0]] : '0;
         unit_idx_in       = final_unit ? 3'd0 : unit_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_idx_ff  <= unit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_unit_ff   <= rsp_out_unit_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_terminator_ff <= rsp_terminator_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_unit   = rsp_out_unit_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_terminator = rsp_terminator_ff;

endmodule

[rtl/unicode_transcoder.sv]
// Top level of the Unicode transcoder: configuration registers and the
// front decoder, queue and back encoder. Depends on utc_pkg and all submodules.
`timescale 1ns / 1ps

// The transcoder takes one source code unit per request and returns the same
// text in the target form, one code unit per response. A request is accepted
// in the cycle after the previous one whenever the queue has room. The response
// port sets the rate: each request causes from zero responses (a UTF-8 lead
// byte or a UTF-16 high surrogate) up to five (a four-byte UTF-8 sequence plus
// the string terminator). A value with no encoding in the target form is
// dropped by the encoder and causes no response.
// The queue of QUEUE_DEPTH decoded entries lets the decoder run ahead while
// the encoder drains a long sequence. Write the format registers only while
// the block is idle; the configuration port is always ready.

module unicode_transcoder import utc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [1:0]                 csr_write_data,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_code_unit,
   input  logic                       req_last_unit,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_out_unit,
   output logic                       rsp_run_last,
   output logic                       rsp_terminator
);

   logic [1:0]           source_format_ff, source_format_in;
   logic [1:0]           target_format_ff, target_format_in;
   logic                 push_valid;
   logic                 pop;
   utc_entry_type        push_data;
   utc_entry_type        head_data;
   utc_queue_status_type queue_status;

   assign csr_ready = 1'b1;

   // Format register writes; unknown indexes are ignored.
   always_comb begin
      source_format_in = source_format_ff;
      target_format_in = target_format_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOURCE_FORMAT: source_format_in = csr_write_data;
            CSR_TARGET_FORMAT: target_format_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= SOURCE_FORMAT_RESET;
         target_format_ff <= TARGET_FORMAT_RESET;
      end else begin
         source_format_ff <= source_format_in;
         target_format_ff <= target_format_in;
      end
   end

   utc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .source_format (source_format_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .queue_status  (queue_status),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   utc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .status     (queue_status)
   );

   utc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .target_format  (target_format_ff),
      .head_data      (head_data),
      .queue_status   (queue_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_unit   (rsp_out_unit),
      .rsp_run_last   (rsp_run_last),
      .rsp_terminator (rsp_terminator)
   );

endmodule
